@@ rtl/core/hrd_pkg.sv @@
`default_nettype none

package hrd_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       consumed;
        logic [1:0] phase;
        logic [9:0] http_status;
        logic       redirect;
        logic       is_chunked;
    } out_item_t;

    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_CL,
        HDR_TE,
        HDR_LOC
    } hdr_t;

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_EOS     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] PHASE_PARSING = 2'd0;
    localparam logic [1:0] PHASE_DONE    = 2'd1;
    localparam logic [1:0] PHASE_ERROR   = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [9:0] STATUS_MIN      = 10'd100;
    localparam logic [9:0] STATUS_MAX      = 10'd599;
    localparam logic [9:0] STATUS_CAP      = 10'd1000;
    localparam logic [9:0] ST_NO_CONTENT   = 10'd204;
    localparam logic [9:0] ST_NOT_MODIFIED = 10'd304;
    localparam logic [9:0] ST_MOVED        = 10'd301;
    localparam logic [9:0] ST_FOUND        = 10'd302;
    localparam logic [9:0] ST_SEE_OTHER    = 10'd303;
    localparam logic [9:0] ST_TEMP_REDIR   = 10'd307;
    localparam logic [9:0] ST_PERM_REDIR   = 10'd308;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_L  = 8'h6C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [8*5-1:0]  TAG_TEXT  = "HTTP/";
    localparam logic [8*7-1:0]  WORD_TEXT = "chunked";
    localparam logic [8*14-1:0] NAME_CL   = "content-length";
    localparam logic [8*17-1:0] NAME_TE   = "transfer-encoding";
    localparam logic [8*8-1:0]  NAME_LOC  = "location";

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'd32;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic digit_ok(input logic [7:0] c, input logic hex);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39);
        if (hex && ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)))
            r = 1'b1;
        return r;
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            r = c - 8'h57;
        else
            r = c - 8'h37;
        return r[3:0];
    endfunction

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx < 3'd5)
            r = TAG_TEXT[8*(4-int'(idx)) +: 8];
        return r;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx < 3'd7)
            r = WORD_TEXT[8*(6-int'(idx)) +: 8];
        return r;
    endfunction

    function automatic logic [7:0] name_char(input hdr_t h, input logic [4:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (h)
            HDR_CL:  if (idx < 5'd14) r = NAME_CL[8*(13-int'(idx)) +: 8];
            HDR_TE:  if (idx < 5'd17) r = NAME_TE[8*(16-int'(idx)) +: 8];
            HDR_LOC: if (idx < 5'd8)  r = NAME_LOC[8*(7-int'(idx)) +: 8];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] name_last(input hdr_t h);
        logic [4:0] r;
        case (h)
            HDR_CL:  r = 5'd13;
            HDR_TE:  r = 5'd16;
            HDR_LOC: r = 5'd7;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/http_response_deframer.sv @@
// HTTP/1.1 response deframer.
// Input channel in_valid/in_ready/in_item carries one command per transfer:
// a response byte, end of stream, or restart for a new response. Output
// channel out_valid/out_ready/out_item returns exactly one result per input
// transfer: body byte flag and value, consumed flag, phase, status code,
// redirect flag and chunked flag.
// Ordinary bytes (body bytes, bytes inside a line, commands) need no scan:
// the result is registered at the input transfer and the next item can be
// taken in the following cycle if the receiver takes that result.
// A line end in the status, header or chunk size phase (but not the blank
// line that ends the headers) starts a scan of the line store: each byte is
// read from the line memory, then evaluated in a shared multiply-accumulate /
// compare unit, and a finish step loads the result.
// in_ready is low while a scan runs and while a result waits that the
// receiver has not taken; a stalled receiver simply holds the block.
// Reset (rst_n low) returns to the status line phase with empty line store,
// status 0, unknown length and cleared flags; no clearing pass is needed.
`default_nettype none

module http_response_deframer #(
    parameter int LINE_BYTES          = 256,
    parameter int LOCATION_BYTES      = 256,
    parameter int ENCODING_SCAN_BYTES = 48
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hrd_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hrd_pkg::out_item_t      out_item
);
    import hrd_pkg::*;

    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam int ENC_W  = $clog2(ENCODING_SCAN_BYTES);

    typedef enum logic [3:0] {
        PH_STATUS,
        PH_HEADERS,
        PH_BODY_LEN,
        PH_BODY_EOF,
        PH_CHUNK_SIZE,
        PH_CHUNK_DATA,
        PH_CHUNK_CRLF,
        PH_TRAILER,
        PH_DONE,
        PH_ERROR
    } ph_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_EVAL,
        SQ_FIN
    } sq_t;

    typedef enum logic [3:0] {
        SC_TAG,
        SC_FIND_SP,
        SC_SKIP_SP,
        SC_STATUS_DIG,
        SC_NAME,
        SC_COLON_SP,
        SC_BLANK,
        SC_NUM_WS,
        SC_NUM_FIRST,
        SC_NUM_ZERO,
        SC_NUM_X,
        SC_NUM_DIG,
        SC_TE,
        SC_LOC,
        SC_STOP
    } sc_t;

    sq_t              sq_reg, sq_next;
    ph_t              ph_reg, ph_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [7:0]       last_reg, last_next;
    logic [9:0]       status_reg, status_next;
    logic             decl_known_reg, decl_known_next;
    logic [47:0]      decl_reg, decl_next;
    logic [47:0]      body_cnt_reg, body_cnt_next;
    logic [47:0]      chunk_rem_reg, chunk_rem_next;
    logic             chunked_reg, chunked_next;
    logic             loc_reg, loc_next;

    logic [ADDR_W-1:0] scan_len_reg, scan_len_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] vs_reg, vs_next;
    sc_t              sub_reg, sub_next;
    hdr_t             hdr_reg, hdr_next;
    logic [47:0]      acc_reg, acc_next;
    logic             any_reg, any_next;
    logic             neg_reg, neg_next;
    logic             bad_reg, bad_next;
    logic [2:0]       k_reg, k_next;
    logic [ENC_W-1:0] n_reg, n_next;
    logic             hit_reg, hit_next;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [7:0]       line_mem [LINE_BYTES];
    logic [7:0]       rd_data_reg;
    logic             mem_we;

    logic             in_fire;
    logic             out_free;

    // scan datapath
    logic [7:0]       b;
    logic [7:0]       fb;
    logic             base16;
    logic             dok;
    logic [3:0]       dval;
    sc_t              eff;
    logic [47:0]      acc_in;
    logic [52:0]      mac_base;
    logic [52:0]      mac;
    logic [47:0]      mac_sat;
    logic [47:0]      mac_cap;
    logic [ADDR_W:0]  pos_inc;
    logic [ADDR_W-1:0] loc_len;
    logic [ADDR_W-1:0] len_strip;
    logic [47:0]      body_inc;
    logic             load_out;
    logic             res_valid;
    logic             res_consumed;

    function automatic logic [1:0] phase_code(input ph_t p);
        logic [1:0] r;
        case (p)
            PH_DONE:  r = PHASE_DONE;
            PH_ERROR: r = PHASE_ERROR;
            default:  r = PHASE_PARSING;
        endcase
        return r;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (sq_reg == SQ_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // shared multiply-accumulate with saturation
    assign b        = rd_data_reg;
    assign fb       = fold_case(b);
    assign base16   = (ph_reg == PH_CHUNK_SIZE);
    assign dok      = digit_ok(b, base16);
    assign dval     = digit_val(b);
    assign acc_in   = (eff == SC_SKIP_SP || eff == SC_NUM_FIRST || eff == SC_NUM_X)
                      ? 48'd0 : acc_reg;
    assign mac_base = base16 ? {1'b0, acc_in, 4'b0000}
                             : ({2'b00, acc_in, 3'b000} + {4'b0000, acc_in, 1'b0});
    assign mac      = mac_base + {49'd0, dval};
    assign mac_sat  = (mac > {5'd0, MAX48}) ? MAX48 : mac[47:0];
    assign mac_cap  = (mac > {43'd0, STATUS_CAP}) ? {38'd0, STATUS_CAP} : mac[47:0];

    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign loc_len   = (sub_reg == SC_LOC) ? (end_reg - vs_reg) : '0;
    assign len_strip = (len_reg != '0 && last_reg == CH_CR) ? (len_reg - 1'b1) : len_reg;
    assign body_inc  = (body_cnt_reg != MAX48) ? (body_cnt_reg + 48'd1) : body_cnt_reg;

    // effective scan state: a value byte after the blanks is handled right away
    always_comb
    begin
        eff = sub_reg;
        if (sub_reg == SC_BLANK && b != CH_SP && b != CH_TAB)
        begin
            case (hdr_reg)
                HDR_CL:  eff = SC_NUM_WS;
                HDR_TE:  eff = SC_TE;
                HDR_LOC: eff = SC_LOC;
                default: eff = SC_STOP;
            endcase
        end
        if (eff == SC_NUM_WS && !is_ws(b) && b != CH_PLUS && b != CH_MINUS)
            eff = SC_NUM_FIRST;
    end

    always_comb
    begin
        sq_next         = sq_reg;
        ph_next         = ph_reg;
        len_next        = len_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        decl_known_next = decl_known_reg;
        decl_next       = decl_reg;
        body_cnt_next   = body_cnt_reg;
        chunk_rem_next  = chunk_rem_reg;
        chunked_next    = chunked_reg;
        loc_next        = loc_reg;
        scan_len_next   = scan_len_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        vs_next         = vs_reg;
        sub_next        = sub_reg;
        hdr_next        = hdr_reg;
        acc_next        = acc_reg;
        any_next        = any_reg;
        neg_next        = neg_reg;
        bad_next        = bad_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        hit_next        = hit_reg;
        mem_we          = 1'b0;
        load_out        = 1'b0;
        res_valid       = 1'b0;
        res_consumed    = 1'b1;

        case (sq_reg)
            SQ_IDLE:
            begin
                if (in_fire)
                begin
                    load_out = 1'b1;
                    case (in_item.cmd)
                        CMD_RESTART:
                        begin
                            ph_next         = PH_STATUS;
                            len_next        = '0;
                            status_next     = '0;
                            decl_known_next = 1'b0;
                            decl_next       = '0;
                            body_cnt_next   = '0;
                            chunk_rem_next  = '0;
                            chunked_next    = 1'b0;
                            loc_next        = 1'b0;
                        end
                        CMD_EOS:
                        begin
                            if (ph_reg == PH_BODY_EOF)
                                ph_next = PH_DONE;
                            else if (ph_reg != PH_DONE)
                                ph_next = PH_ERROR;
                        end
                        CMD_DATA:
                        begin
                            if (ph_reg == PH_DONE || ph_reg == PH_ERROR)
                            begin
                                res_consumed = 1'b0;
                            end
                            else if (ph_reg == PH_BODY_LEN || ph_reg == PH_BODY_EOF ||
                                     ph_reg == PH_CHUNK_DATA)
                            begin
                                res_valid     = 1'b1;
                                body_cnt_next = body_inc;
                                if (ph_reg == PH_BODY_LEN && body_inc >= decl_reg)
                                    ph_next = PH_DONE;
                                if (ph_reg == PH_CHUNK_DATA)
                                begin
                                    if (chunk_rem_reg <= 48'd1)
                                    begin
                                        chunk_rem_next = '0;
                                        ph_next        = PH_CHUNK_CRLF;
                                        len_next       = '0;
                                    end
                                    else
                                    begin
                                        chunk_rem_next = chunk_rem_reg - 48'd1;
                                    end
                                end
                            end
                            else if (in_item.data_byte != CH_LF)
                            begin
                                if (32'(len_reg) < LINE_BYTES - 1)
                                begin
                                    mem_we    = 1'b1;
                                    len_next  = len_reg + 1'b1;
                                    last_next = in_item.data_byte;
                                end
                            end
                            else
                            begin
                                len_next = '0;
                                case (ph_reg)
                                    PH_STATUS, PH_CHUNK_SIZE, PH_HEADERS:
                                    begin
                                        if (ph_reg == PH_HEADERS && len_strip == '0)
                                        begin
                                            if (status_reg == ST_NO_CONTENT ||
                                                status_reg == ST_NOT_MODIFIED)
                                                ph_next = PH_DONE;
                                            else if (chunked_reg)
                                                ph_next = PH_CHUNK_SIZE;
                                            else if (decl_known_reg && decl_reg == '0)
                                                ph_next = PH_DONE;
                                            else if (decl_known_reg)
                                                ph_next = PH_BODY_LEN;
                                            else
                                                ph_next = PH_BODY_EOF;
                                        end
                                        else
                                        begin
                                            // line scan; result comes at the finish step
                                            load_out      = 1'b0;
                                            scan_len_next = len_strip;
                                            pos_next      = '0;
                                            end_next      = '0;
                                            hdr_next      = HDR_NONE;
                                            acc_next      = '0;
                                            any_next      = 1'b0;
                                            neg_next      = 1'b0;
                                            bad_next      = 1'b0;
                                            k_next        = '0;
                                            n_next        = '0;
                                            hit_next      = 1'b0;
                                            case (ph_reg)
                                                PH_STATUS:  sub_next = SC_TAG;
                                                PH_HEADERS: sub_next = SC_NAME;
                                                default:    sub_next = SC_NUM_WS;
                                            endcase
                                            sq_next = (len_strip == '0) ? SQ_FIN : SQ_READ;
                                        end
                                    end
                                    PH_CHUNK_CRLF:
                                        ph_next = (len_strip != '0) ? PH_ERROR : PH_CHUNK_SIZE;
                                    PH_TRAILER:
                                        if (len_strip == '0)
                                            ph_next = PH_DONE;
                                    default:
                                        ph_next = PH_ERROR;
                                endcase
                            end
                        end
                        default:
                            res_consumed = 1'b0;
                    endcase
                end
            end

            SQ_READ:
                sq_next = SQ_EVAL;

            SQ_EVAL:
            begin
                if (b == CH_NUL)
                begin
                    end_next = pos_reg;
                    sq_next  = SQ_FIN;
                end
                else
                begin
                    if (sub_reg == SC_BLANK && b != CH_SP && b != CH_TAB)
                        vs_next = pos_reg;
                    case (eff)
                        SC_TAG:
                        begin
                            if (b != tag_char(3'(pos_reg)))
                            begin
                                bad_next = 1'b1;
                                sub_next = SC_STOP;
                            end
                            else if (32'(pos_reg) == 4)
                            begin
                                sub_next = SC_FIND_SP;
                            end
                        end
                        SC_FIND_SP:
                            if (b == CH_SP)
                                sub_next = SC_SKIP_SP;
                        SC_SKIP_SP:
                        begin
                            if (b != CH_SP)
                            begin
                                if (dok)
                                begin
                                    acc_next = mac_cap;
                                    sub_next = SC_STATUS_DIG;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                    sub_next = SC_STOP;
                                end
                            end
                        end
                        SC_STATUS_DIG:
                        begin
                            if (dok)
                                acc_next = mac_cap;
                            else
                                sub_next = SC_STOP;
                        end
                        SC_NAME:
                        begin
                            if (pos_reg == '0)
                            begin
                                if (fb == CH_LO_C)
                                    hdr_next = HDR_CL;
                                else if (fb == CH_LO_T)
                                    hdr_next = HDR_TE;
                                else if (fb == CH_LO_L)
                                    hdr_next = HDR_LOC;
                                else
                                    sub_next = SC_STOP;
                            end
                            else if (fb != name_char(hdr_reg, 5'(pos_reg)))
                            begin
                                hdr_next = HDR_NONE;
                                sub_next = SC_STOP;
                            end
                            else if (5'(pos_reg) == name_last(hdr_reg))
                            begin
                                sub_next = SC_COLON_SP;
                            end
                        end
                        SC_COLON_SP:
                        begin
                            if (b == CH_COLON)
                                sub_next = SC_BLANK;
                            else if (b != CH_SP)
                            begin
                                hdr_next = HDR_NONE;
                                sub_next = SC_STOP;
                            end
                        end
                        SC_BLANK:
                            sub_next = SC_BLANK;
                        SC_NUM_WS:
                        begin
                            if (b == CH_PLUS || b == CH_MINUS)
                            begin
                                neg_next = (b == CH_MINUS);
                                sub_next = SC_NUM_FIRST;
                            end
                            else
                                sub_next = SC_NUM_WS;
                        end
                        SC_NUM_FIRST:
                        begin
                            if (base16 && b == CH_ZERO)
                            begin
                                any_next = 1'b1;
                                acc_next = '0;
                                sub_next = SC_NUM_ZERO;
                            end
                            else if (dok)
                            begin
                                any_next = 1'b1;
                                acc_next = mac_sat;
                                sub_next = SC_NUM_DIG;
                            end
                            else
                                sub_next = SC_STOP;
                        end
                        SC_NUM_ZERO:
                        begin
                            if (b == CH_LO_X || b == CH_UP_X)
                                sub_next = SC_NUM_X;
                            else if (dok)
                            begin
                                acc_next = mac_sat;
                                sub_next = SC_NUM_DIG;
                            end
                            else
                                sub_next = SC_STOP;
                        end
                        SC_NUM_X:
                        begin
                            if (dok)
                            begin
                                acc_next = mac_sat;
                                sub_next = SC_NUM_DIG;
                            end
                            else
                                sub_next = SC_STOP;
                        end
                        SC_NUM_DIG:
                        begin
                            if (dok)
                                acc_next = mac_sat;
                            else
                                sub_next = SC_STOP;
                        end
                        SC_TE:
                        begin
                            sub_next = SC_TE;
                            if (32'(n_reg) < ENCODING_SCAN_BYTES - 1)
                            begin
                                n_next = n_reg + 1'b1;
                                if (fb == word_char(k_reg))
                                begin
                                    if (k_reg == 3'd6)
                                    begin
                                        hit_next = 1'b1;
                                        sub_next = SC_STOP;
                                    end
                                    else
                                        k_next = k_reg + 3'd1;
                                end
                                else
                                    k_next = (fb == CH_LO_C) ? 3'd1 : 3'd0;
                            end
                            else
                                sub_next = SC_STOP;
                        end
                        SC_LOC:
                            sub_next = SC_LOC;
                        default:
                            sub_next = SC_STOP;
                    endcase

                    pos_next = pos_reg + 1'b1;
                    if (sub_next == SC_STOP)
                    begin
                        end_next = pos_inc[ADDR_W-1:0];
                        sq_next  = SQ_FIN;
                    end
                    else if (pos_inc == {1'b0, scan_len_reg})
                    begin
                        end_next = scan_len_reg;
                        sq_next  = SQ_FIN;
                    end
                    else
                        sq_next = SQ_READ;
                end
            end

            SQ_FIN:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    sq_next  = SQ_IDLE;
                    case (ph_reg)
                        PH_STATUS:
                        begin
                            if (!bad_reg && (sub_reg == SC_STATUS_DIG || sub_reg == SC_STOP) &&
                                acc_reg >= {38'd0, STATUS_MIN} &&
                                acc_reg <= {38'd0, STATUS_MAX})
                            begin
                                status_next = acc_reg[9:0];
                                ph_next     = PH_HEADERS;
                            end
                            else
                                ph_next = PH_ERROR;
                        end
                        PH_HEADERS:
                        begin
                            case (hdr_reg)
                                HDR_CL:
                                    if (any_reg && (!neg_reg || acc_reg == '0))
                                    begin
                                        decl_known_next = 1'b1;
                                        decl_next       = neg_reg ? 48'd0 : acc_reg;
                                    end
                                HDR_TE:
                                    if (hit_reg)
                                        chunked_next = 1'b1;
                                HDR_LOC:
                                    if ((sub_reg == SC_BLANK || sub_reg == SC_LOC) &&
                                        32'(loc_len) < LOCATION_BYTES)
                                        loc_next = (loc_len != '0);
                                default:
                                    loc_next = loc_reg;
                            endcase
                        end
                        PH_CHUNK_SIZE:
                        begin
                            if (!any_reg || (neg_reg && acc_reg != '0))
                                ph_next = PH_ERROR;
                            else if (acc_reg == '0)
                                ph_next = PH_TRAILER;
                            else
                            begin
                                chunk_rem_next = acc_reg;
                                ph_next        = PH_CHUNK_DATA;
                            end
                        end
                        default:
                            ph_next = PH_ERROR;
                    endcase
                end
            end

            default:
                sq_next = SQ_IDLE;
        endcase

        out_item_next.body_valid  = res_valid;
        out_item_next.body_byte   = res_valid ? in_item.data_byte : 8'd0;
        out_item_next.consumed    = res_consumed;
        out_item_next.phase       = phase_code(ph_next);
        out_item_next.http_status = status_next;
        out_item_next.redirect    = loc_next &&
                                    (status_next == ST_MOVED || status_next == ST_FOUND ||
                                     status_next == ST_SEE_OTHER ||
                                     status_next == ST_TEMP_REDIR ||
                                     status_next == ST_PERM_REDIR);
        out_item_next.is_chunked  = chunked_next;

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg         <= SQ_IDLE;
            ph_reg         <= PH_STATUS;
            len_reg        <= '0;
            last_reg       <= '0;
            status_reg     <= '0;
            decl_known_reg <= 1'b0;
            decl_reg       <= '0;
            body_cnt_reg   <= '0;
            chunk_rem_reg  <= '0;
            chunked_reg    <= 1'b0;
            loc_reg        <= 1'b0;
            scan_len_reg   <= '0;
            pos_reg        <= '0;
            end_reg        <= '0;
            vs_reg         <= '0;
            sub_reg        <= SC_STOP;
            hdr_reg        <= HDR_NONE;
            acc_reg        <= '0;
            any_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            bad_reg        <= 1'b0;
            k_reg          <= '0;
            n_reg          <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            sq_reg         <= sq_next;
            ph_reg         <= ph_next;
            len_reg        <= len_next;
            last_reg       <= last_next;
            status_reg     <= status_next;
            decl_known_reg <= decl_known_next;
            decl_reg       <= decl_next;
            body_cnt_reg   <= body_cnt_next;
            chunk_rem_reg  <= chunk_rem_next;
            chunked_reg    <= chunked_next;
            loc_reg        <= loc_next;
            scan_len_reg   <= scan_len_next;
            pos_reg        <= pos_next;
            end_reg        <= end_next;
            vs_reg         <= vs_next;
            sub_reg        <= sub_next;
            hdr_reg        <= hdr_next;
            acc_reg        <= acc_next;
            any_reg        <= any_next;
            neg_reg        <= neg_next;
            bad_reg        <= bad_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            if (load_out)
                out_item_reg <= out_item_next;
        end
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[len_reg] <= in_item.data_byte;
        rd_data_reg <= line_mem[pos_reg];
    end

endmodule

`default_nettype wire
